FILE: design/sssp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sssp_pkg
// Shared types and constants for the shortest path engine.
// ---------------------------------------------------------------------------
package sssp_pkg;

  localparam int unsigned NodeCountDef    = 1024;
  localparam int unsigned EdgeCapacityDef = 16384;
  localparam int unsigned WeightBitsDef   = 16;

  localparam logic [31:0] Unreached = 32'hFFFF_FFFF;
  localparam logic [31:0] DistMax   = 32'hFFFF_FFFE;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpAdd   = 2'd1;
  localparam logic [1:0] OpRun   = 2'd2;
  localparam logic [1:0] OpQuery = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  node_a;
    logic [9:0]  node_b;
    logic [15:0] edge_weight;
  } sssp_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] distance;
    logic [9:0]  predecessor;
    logic        reachable;
  } sssp_rsp_t;

  // heap key compare operands passed from sequencer to compare unit
  typedef struct packed {
    logic [51:0] key_a;
    logic [51:0] key_b;
  } sssp_cmp_t;

endpackage

FILE: design/sssp_cmp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sssp_cmp
// Shared unit: saturating distance add and key compare.
// ---------------------------------------------------------------------------
module sssp_cmp import sssp_pkg::*; #(
  parameter int unsigned WeightBits = WeightBitsDef
) (
  input  logic [31:0]         base_i,
  input  logic [WeightBits-1:0] weight_i,
  input  sssp_cmp_t           cmp_i,
  output logic [31:0]         sum_o,
  output logic                less_o
);
  logic [32:0] sum_w;
  assign sum_w  = {1'b0, base_i} + 33'(weight_i);
  assign sum_o  = (sum_w > {1'b0, DistMax}) ? DistMax : sum_w[31:0];
  assign less_o = cmp_i.key_a < cmp_i.key_b;
endmodule

FILE: design/single_source_shortest_path_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// single_source_shortest_path_top
// Dijkstra engine with linked adjacency lists and a binary min-heap.
// ---------------------------------------------------------------------------
// One request at a time: busy is high from the cycle after the accepting edge
// until the response. done_o is high for a single cycle, the same cycle in
// which busy falls, and the response sits on rsp_o from then until the next
// request is taken; the receiver cannot stall it. After reset busy stays high
// while the node tables are swept. Add edge reads the list head and then
// writes the edge; query reads the distance table and then sets the response;
// clear sweeps the list heads. A run first sweeps the distance table, then
// works the heap with one access per memory per cycle: a pop reads the root
// and the last entry and sifts down level by level, the stale check follows,
// an accepted node fetches its list head and relaxes every edge in the list,
// and every push rises level by level. The run ends once the heap is empty.
module single_source_shortest_path_top import sssp_pkg::*; #(
  parameter int unsigned NodeCount    = NodeCountDef,
  parameter int unsigned EdgeCapacity = EdgeCapacityDef,
  parameter int unsigned WeightBits   = WeightBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  sssp_req_t req_i,
  output logic      busy,
  output logic      done_o,
  output sssp_rsp_t rsp_o
);
  localparam int unsigned NW = (NodeCount > 1) ? $clog2(NodeCount) : 1;
  localparam int unsigned EW = $clog2(EdgeCapacity + 1);
  localparam int unsigned EA = $clog2(EdgeCapacity);
  localparam int unsigned HD = EdgeCapacity + 1;
  localparam int unsigned HW = $clog2(HD + 1);
  localparam int unsigned HA = $clog2(HD);
  localparam logic [EW-1:0] NullLink = EW'(EdgeCapacity);

  typedef enum logic [4:0] {
    StIdle, StRst, StClr, StAddRd, StAddWr, StQryRd, StQryOut, StInit,
    StPop0, StPop1, StPop2, StDnRd, StDnL, StDnR, StDnCmp, StChk, StChkRd,
    StEdge, StEdgeHd, StEdgeRd, StEdgeTgt, StRelax, StUpRd, StUpCmp, StDone
  } st_e;

  logic [EW-1:0] head_mem [NodeCount];
  logic [NW-1:0] tgt_mem  [EdgeCapacity];
  logic [EW-1:0] link_mem [EdgeCapacity];
  logic [WeightBits-1:0] cost_mem [EdgeCapacity];
  logic [31:0]   dist_mem [NodeCount];
  logic [NW-1:0] prev_mem [NodeCount];
  logic [51:0]   heap_mem [HD];

  st_e           state_q;
  sssp_req_t     req_q;
  logic [EW-1:0] ecnt_q;
  logic [HW-1:0] fill_q;
  logic [NW:0]   ncnt_q;
  logic [HA:0]   hi_q, hc_q;
  logic [51:0]   key_q, ka_q, top_q;
  logic [EW-1:0] e_q;
  logic [NW-1:0] u_q, v_q;
  logic [31:0]   du_q;
  logic [WeightBits-1:0] w_q;
  logic [EW-1:0] hrd_q;
  logic [NW-1:0] trd_q;
  logic [EW-1:0] lrd_q;
  logic [WeightBits-1:0] crd_q;
  logic [31:0]   drd_q;
  logic [NW-1:0] prd_q;
  logic [51:0]   krd_q;
  sssp_rsp_t     rsp_q;
  logic          done_q;

  logic [31:0] sum_w;
  logic        less_w;
  sssp_cmp_t   cmp_w;

  sssp_cmp #(.WeightBits(WeightBits)) u_cmp (
    .base_i(du_q), .weight_i(w_q), .cmp_i(cmp_w), .sum_o(sum_w), .less_o(less_w)
  );

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // memory port control (one access each per cycle)
  logic          h_we, d_we, hp_we;
  logic [NW-1:0] h_wa, h_ra, d_wa, d_ra;
  logic [EW-1:0] h_wd;
  logic [31:0]   d_wd;
  logic [NW-1:0] p_wd;
  logic          e_we;
  logic [EA-1:0] e_wa, e_ra;
  logic [HA-1:0] hp_wa, hp_ra;
  logic [51:0]   hp_wd;

  logic          a_ok, b_ok;
  logic          ncnt_last, src_hit;
  logic [HA:0]   lch, rch, par;
  logic          lch_ok, rch_ok;
  assign a_ok      = (32'(req_q.node_a) < NodeCount);
  assign b_ok      = (32'(req_q.node_b) < NodeCount);
  assign ncnt_last = (ncnt_q == (NW+1)'(NodeCount - 1));
  assign src_hit   = a_ok && (ncnt_q[NW-1:0] == NW'(req_q.node_a));
  assign lch       = {hi_q[HA-1:0], 1'b1};
  assign rch       = lch + 1'b1;
  assign par       = (hi_q - 1'b1) >> 1;
  assign lch_ok    = (lch < (HA+1)'(fill_q));
  assign rch_ok    = (rch < (HA+1)'(fill_q));

  // operands of the shared compare
  always_comb begin
    cmp_w = '{key_a: ka_q, key_b: key_q};
    case (state_q)
      StChkRd: cmp_w = '{key_a: {drd_q, 20'd0}, key_b: {top_q[51:20], 20'd0}};
      StDnR:   cmp_w = '{key_a: krd_q, key_b: ka_q};
      StRelax: cmp_w = '{key_a: {sum_w, 20'd0}, key_b: {drd_q, 20'd0}};
      StUpCmp: cmp_w = '{key_a: key_q, key_b: krd_q};
      default: ;
    endcase
  end

  always_comb begin
    h_we = 1'b0; h_wa = NW'(req_q.node_a); h_wd = ecnt_q;
    h_ra = NW'(req_q.node_a);
    d_we = 1'b0; d_wa = v_q; d_wd = sum_w; p_wd = u_q; d_ra = NW'(req_q.node_a);
    e_we = 1'b0; e_wa = ecnt_q[EA-1:0]; e_ra = e_q[EA-1:0];
    hp_we = 1'b0; hp_wa = hi_q[HA-1:0]; hp_wd = key_q; hp_ra = hi_q[HA-1:0];
    case (state_q)
      StRst: begin
        h_we = 1'b1; h_wa = ncnt_q[NW-1:0]; h_wd = NullLink;
        d_we = 1'b1; d_wa = ncnt_q[NW-1:0]; d_wd = Unreached; p_wd = '0;
      end
      StClr: begin
        h_we = 1'b1; h_wa = ncnt_q[NW-1:0]; h_wd = NullLink;
      end
      StAddWr: begin
        h_we = a_ok && b_ok && (ecnt_q != NullLink);
        e_we = h_we;
      end
      StInit: begin
        d_we = 1'b1; d_wa = ncnt_q[NW-1:0];
        d_wd = src_hit ? 32'd0 : Unreached; p_wd = '0;
        // source key (distance zero) goes straight to the heap root
        hp_we = a_ok && ncnt_last; hp_wa = '0; hp_wd = 52'(req_q.node_a);
      end
      StPop0: hp_ra = '0;
      StPop1: hp_ra = HA'(fill_q - 1'b1);
      StDnRd: begin
        hp_we = !lch_ok;
        hp_ra = lch[HA-1:0];
      end
      StDnL: hp_ra = rch[HA-1:0];
      StDnCmp: begin
        hp_we = 1'b1; hp_wd = less_w ? ka_q : key_q;
      end
      StChk:     d_ra = top_q[NW-1:0];
      StEdge:    h_ra = u_q;
      StEdgeTgt: d_ra = trd_q;
      StRelax:   d_we = less_w;
      StUpRd: begin
        hp_we = (hi_q == '0);
        hp_ra = par[HA-1:0];
      end
      StUpCmp: begin
        hp_we = 1'b1; hp_wd = less_w ? krd_q : key_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (h_we) head_mem[h_wa] <= h_wd;
    hrd_q <= head_mem[h_ra];
    if (e_we) begin
      tgt_mem[e_wa]  <= NW'(req_q.node_b);
      cost_mem[e_wa] <= WeightBits'(req_q.edge_weight);
      link_mem[e_wa] <= hrd_q;
    end
    trd_q <= tgt_mem[e_ra];
    lrd_q <= link_mem[e_ra];
    crd_q <= cost_mem[e_ra];
    if (d_we) begin
      dist_mem[d_wa] <= d_wd;
      prev_mem[d_wa] <= p_wd;
    end
    drd_q <= dist_mem[d_ra];
    prd_q <= prev_mem[d_ra];
    if (hp_we) heap_mem[hp_wa] <= hp_wd;
    krd_q <= heap_mem[hp_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRst; ecnt_q <= '0; fill_q <= '0; ncnt_q <= '0;
      done_q <= 1'b0; rsp_q <= '0; req_q <= '0;
      hi_q <= '0; hc_q <= '0; key_q <= '0; ka_q <= '0; top_q <= '0;
      e_q <= '0; u_q <= '0; v_q <= '0; du_q <= '0; w_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: if (start) begin
          req_q <= req_i; ncnt_q <= '0;
          rsp_q <= '0;
          case (req_i.opcode)
            OpClear: state_q <= StClr;
            OpAdd:   state_q <= StAddRd;
            OpRun:   state_q <= StInit;
            OpQuery: state_q <= StQryRd;
            default: state_q <= StIdle;
          endcase
        end
        StRst: begin
          ncnt_q <= ncnt_q + 1'b1;
          if (ncnt_last) state_q <= StIdle;
        end
        StClr: begin
          ncnt_q <= ncnt_q + 1'b1;
          if (ncnt_last) begin
            ecnt_q <= '0; state_q <= StDone;
          end
        end
        StAddRd: state_q <= StAddWr;
        StAddWr: begin
          if (a_ok && b_ok) begin
            if (ecnt_q == NullLink) rsp_q.status <= 1'b1;
            else ecnt_q <= ecnt_q + 1'b1;
          end
          state_q <= StDone;
        end
        StQryRd: state_q <= StQryOut;
        StQryOut: begin
          if (a_ok && drd_q != Unreached) begin
            rsp_q.distance <= drd_q; rsp_q.predecessor <= 10'(prd_q);
            rsp_q.reachable <= 1'b1;
          end else rsp_q.distance <= Unreached;
          state_q <= StDone;
        end
        StInit: begin
          ncnt_q <= ncnt_q + 1'b1;
          if (ncnt_last) begin
            if (a_ok) begin
              fill_q <= HW'(1); state_q <= StPop0;
            end else begin
              fill_q <= '0; state_q <= StDone;
            end
          end
        end
        // pop: root, then last entry, which sifts down from the root
        StPop0: begin
          if (fill_q == '0) state_q <= StDone;
          else state_q <= StPop1;
        end
        StPop1: begin
          top_q <= krd_q; fill_q <= fill_q - 1'b1; state_q <= StPop2;
        end
        StPop2: begin
          key_q <= krd_q; hi_q <= '0; state_q <= StDnRd;
        end
        StDnRd: state_q <= lch_ok ? StDnL : StChk;
        StDnL: begin
          ka_q <= krd_q; hc_q <= lch; state_q <= StDnR;
        end
        StDnR: begin
          if (rch_ok && less_w) begin
            ka_q <= krd_q; hc_q <= rch;
          end
          state_q <= StDnCmp;
        end
        StDnCmp: begin
          if (less_w) begin
            hi_q <= hc_q; state_q <= StDnRd;
          end else state_q <= StChk;
        end
        StChk: state_q <= StChkRd;
        StChkRd: begin
          // stale entry: a shorter distance was already settled
          if (less_w) state_q <= StPop0;
          else begin
            u_q <= top_q[NW-1:0]; du_q <= drd_q; state_q <= StEdge;
          end
        end
        StEdge: state_q <= StEdgeHd;
        StEdgeHd: begin
          e_q <= hrd_q; state_q <= StEdgeRd;
        end
        StEdgeRd: state_q <= (e_q == NullLink) ? StPop0 : StEdgeTgt;
        StEdgeTgt: begin
          v_q <= trd_q; w_q <= crd_q; e_q <= lrd_q; state_q <= StRelax;
        end
        StRelax: begin
          if (less_w && fill_q != HW'(HD)) begin
            key_q <= {sum_w, 20'(v_q)};
            hi_q <= (HA+1)'(fill_q); fill_q <= fill_q + 1'b1;
            state_q <= StUpRd;
          end else state_q <= StEdgeRd;
        end
        StUpRd: state_q <= (hi_q == '0) ? StEdgeRd : StUpCmp;
        StUpCmp: begin
          if (less_w) begin
            hi_q <= par; state_q <= StUpRd;
          end else state_q <= StEdgeRd;
        end
        StDone: begin
          done_q <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

FILE: design/sssp_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sssp_check
// Port-level checks for the shortest path engine.
// ---------------------------------------------------------------------------
module sssp_check import sssp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input sssp_rsp_t rsp_o
);
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");
  a_unreach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.reachable) |-> (rsp_o.distance != Unreached))
    else $error("reachable with unreached distance");
endmodule

bind single_source_shortest_path_top sssp_check u_sssp_check (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .rsp_o(rsp_o)
);

FILE: tb/sv/tb_single_source_shortest_path_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_single_source_shortest_path_top
// Self-checking bench for the shortest path engine: directed requests from a
// table, then random graph build / run / query phases, each response checked
// against an in-bench Dijkstra model.
// ---------------------------------------------------------------------------
module tb_single_source_shortest_path_top;
  import sssp_pkg::*;

  localparam int NODES = NodeCountDef;
  localparam int EDGES = EdgeCapacityDef;
  localparam int NIL   = EdgeCapacityDef;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  sssp_req_t req_i = '0;
  logic      busy;
  logic      done_o;
  sssp_rsp_t rsp_o;

  single_source_shortest_path_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // graph and path state of the model
  int unsigned       list_head[NODES];
  int unsigned       edge_dst[EDGES];
  int unsigned       edge_next[EDGES];
  int unsigned       edge_wt[EDGES];
  int unsigned       n_edges;
  logic [31:0]       best_dist[NODES];
  logic [9:0]        prev_node[NODES];
  longint unsigned   pq[EDGES+1];
  int unsigned       pq_fill;

  sssp_rsp_t expected_rsp_q[$];
  bit        typed_valid_q[$];
  sssp_rsp_t typed_rsp_q[$];
  int        errors = 0;
  longint    cycles = 0;
  int        burst_left = 0;

  function automatic void pq_push(longint unsigned k);
    int unsigned i, p;
    longint unsigned t;
    if (pq_fill >= EDGES + 1) return;
    i = pq_fill;
    pq_fill++;
    pq[i] = k;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (pq[p] <= pq[i]) break;
      t = pq[p]; pq[p] = pq[i]; pq[i] = t;
      i = p;
    end
  endfunction

  function automatic longint unsigned pq_pop();
    longint unsigned top, t;
    int unsigned i, l, r, s;
    top = pq[0];
    i = 0;
    pq_fill--;
    pq[0] = pq[pq_fill];
    forever begin
      l = 2 * i + 1; r = l + 1; s = i;
      if (l < pq_fill && pq[l] < pq[s]) s = l;
      if (r < pq_fill && pq[r] < pq[s]) s = r;
      if (s == i) break;
      t = pq[s]; pq[s] = pq[i]; pq[i] = t;
      i = s;
    end
    return top;
  endfunction

  function automatic void shortest_paths(int unsigned src);
    longint unsigned key, sum;
    int unsigned u, v, e;
    logic [31:0] d;
    for (int n = 0; n < NODES; n++) begin
      best_dist[n] = Unreached;
      prev_node[n] = '0;
    end
    pq_fill = 0;
    if (src >= NODES) return;
    best_dist[src] = '0;
    pq_push(src);
    while (pq_fill > 0) begin
      key = pq_pop();
      u = 32'(key[19:0]);
      d = key[51:20];
      if (u >= NODES || best_dist[u] < d) continue;
      for (e = list_head[u]; e < NIL; e = edge_next[e]) begin
        v = edge_dst[e];
        sum = longint'(best_dist[u]) + edge_wt[e];
        if (sum > DistMax) sum = DistMax;
        if (v < NODES && sum < best_dist[v]) begin
          best_dist[v] = sum[31:0];
          prev_node[v] = u[9:0];
          pq_push((sum << 20) | v);
        end
      end
    end
  endfunction

  function automatic sssp_rsp_t path_engine_step(sssp_req_t rq);
    sssp_rsp_t r;
    r = '0;
    case (rq.opcode)
      OpClear: begin
        for (int n = 0; n < NODES; n++) list_head[n] = NIL;
        n_edges = 0;
      end
      OpAdd: begin
        if (n_edges >= EDGES) begin
          r.status = 1'b1;
        end else begin
          edge_dst[n_edges]  = 32'(rq.node_b);
          edge_wt[n_edges]   = 32'(rq.edge_weight);
          edge_next[n_edges] = list_head[rq.node_a];
          list_head[rq.node_a] = n_edges;
          n_edges++;
        end
      end
      OpRun: shortest_paths(32'(rq.node_a));
      default: begin
        if (best_dist[rq.node_a] != Unreached) begin
          r.distance    = best_dist[rq.node_a];
          r.predecessor = prev_node[rq.node_a];
          r.reachable   = 1'b1;
        end else begin
          r.distance = Unreached;
        end
      end
    endcase
    return r;
  endfunction

  // accept requests and check responses on the same edge
  always @(posedge clk_i) begin
    sssp_rsp_t pred, want;
    if (rst_ni) begin
      if (start && !busy) begin
        pred = path_engine_step(req_i);
        if (typed_valid_q.pop_front()) begin
          want = typed_rsp_q.pop_front();
          if (want !== pred) begin
            $error("typed row disagrees with model: %h vs %h", want, pred);
            errors++;
          end
          expected_rsp_q.push_back(want);
        end else begin
          void'(typed_rsp_q.pop_front());
          expected_rsp_q.push_back(pred);
        end
      end
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with nothing outstanding: %h", rsp_o);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_o.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, rsp_o.status); errors++;
          end
          if (rsp_o.distance !== want.distance) begin
            $error("distance exp %h got %h", want.distance, rsp_o.distance); errors++;
          end
          if (rsp_o.predecessor !== want.predecessor) begin
            $error("predecessor exp %0d got %0d", want.predecessor, rsp_o.predecessor);
            errors++;
          end
          if (rsp_o.reachable !== want.reachable) begin
            $error("reachable exp %0d got %0d", want.reachable, rsp_o.reachable); errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic issue(sssp_req_t rq, bit typed = 1'b0, sssp_rsp_t want = '0);
    typed_valid_q.push_back(typed);
    typed_rsp_q.push_back(want);
    start <= 1'b1;
    req_i <= rq;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  function automatic sssp_req_t mk(logic [1:0] op, logic [9:0] a, logic [9:0] b,
                                   logic [15:0] w);
    sssp_req_t rq;
    rq.opcode = op; rq.node_a = a; rq.node_b = b; rq.edge_weight = w;
    return rq;
  endfunction

  function automatic sssp_rsp_t mkr(logic s, logic [31:0] d, logic [9:0] p, logic r);
    sssp_rsp_t x;
    x.status = s; x.distance = d; x.predecessor = p; x.reachable = r;
    return x;
  endfunction

  typedef struct {
    sssp_req_t rq;
    bit        typed;
    sssp_rsp_t want;
  } row_t;

  initial begin
    row_t rows[$];
    int   span, nq;
    logic [9:0] a, b;
    logic [15:0] w;

    for (int n = 0; n < NODES; n++) begin
      list_head[n] = NIL; best_dist[n] = Unreached; prev_node[n] = '0;
    end
    n_edges = 0;
    pq_fill = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      '{mk(OpQuery, 10'd5, 10'd0, 16'h0), 1, mkr(0, Unreached, 0, 0)},
      '{mk(OpRun, 10'd1023, 10'h3ff, 16'hffff), 1, mkr(0, 0, 0, 0)},
      '{mk(OpQuery, 10'd1023, 10'd0, 16'h0), 1, mkr(0, 0, 0, 1)},
      '{mk(OpQuery, 10'd0, 10'd0, 16'h0), 1, mkr(0, Unreached, 0, 0)},
      '{mk(OpAdd, 10'd0, 10'd1023, 16'hffff), 1, mkr(0, 0, 0, 0)},
      '{mk(OpAdd, 10'd1023, 10'd0, 16'h0), 1, mkr(0, 0, 0, 0)},
      '{mk(OpAdd, 10'd0, 10'd1, 16'd5), 0, '0},
      '{mk(OpAdd, 10'd1, 10'd1023, 16'd3), 0, '0},
      // equal-length routes to node 2: tie keeps first found
      '{mk(OpAdd, 10'd0, 10'd2, 16'd8), 0, '0},
      '{mk(OpAdd, 10'd1, 10'd2, 16'd3), 0, '0},
      '{mk(OpAdd, 10'd3, 10'd3, 16'd1), 0, '0},
      '{mk(OpRun, 10'd0, 10'd0, 16'd0), 1, mkr(0, 0, 0, 0)},
      '{mk(OpQuery, 10'd0, 10'd0, 16'h0), 1, mkr(0, 0, 0, 1)},
      '{mk(OpQuery, 10'd1023, 10'd0, 16'h0), 0, '0},
      '{mk(OpQuery, 10'd2, 10'd0, 16'h0), 0, '0},
      '{mk(OpQuery, 10'd3, 10'd0, 16'h0), 1, mkr(0, Unreached, 0, 0)},
      '{mk(OpRun, 10'd1023, 10'd0, 16'd0), 0, '0},
      '{mk(OpQuery, 10'd1, 10'd0, 16'h0), 0, '0},
      // last run outlives a clear
      '{mk(OpClear, 10'h3ff, 10'h3ff, 16'hffff), 1, mkr(0, 0, 0, 0)},
      '{mk(OpQuery, 10'd0, 10'd0, 16'h0), 0, '0},
      '{mk(OpRun, 10'd0, 10'd0, 16'd0), 0, '0},
      '{mk(OpQuery, 10'd1, 10'd0, 16'h0), 1, mkr(0, Unreached, 0, 0)}
    };
    foreach (rows[i]) issue(rows[i].rq, rows[i].typed, rows[i].want);

    // pause until everything outstanding has drained
    start <= 1'b0;
    repeat (2) @(posedge clk_i);
    wait (expected_rsp_q.size() == 0);
    @(posedge clk_i);

    // random graphs: build, run, query
    for (int ph = 0; ph < 18; ph++) begin
      span = ($urandom_range(0, 3) == 0) ? NODES : $urandom_range(2, 24);
      if ($urandom_range(0, 4) != 0)
        issue(mk(OpClear, 10'($urandom()), 10'($urandom()), 16'($urandom())));
      repeat ($urandom_range(3, 20)) begin
        a = 10'($urandom_range(0, span - 1));
        b = 10'($urandom_range(0, span - 1));
        case ($urandom_range(0, 2))
          0: w = 16'($urandom_range(0, 3));
          1: w = 16'($urandom_range(0, 300));
          default: w = 16'($urandom());
        endcase
        issue(mk(OpAdd, a, b, w));
      end
      issue(mk(OpRun, 10'($urandom_range(0, span - 1)), 10'($urandom()),
               16'($urandom())));
      nq = $urandom_range(3, 12);
      repeat (nq) begin
        a = ($urandom_range(0, 5) == 0) ? 10'($urandom()) : 10'($urandom_range(0, span - 1));
        issue(mk(OpQuery, a, 10'($urandom()), 16'($urandom())));
      end
      // noise: a stray op with random fields
      if ($urandom_range(0, 2) == 0)
        issue(mk(2'($urandom()), 10'($urandom()), 10'($urandom()), 16'($urandom())));
    end

    start <= 1'b0;
    repeat (2) @(posedge clk_i);
    wait (expected_rsp_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
